@@ rtl/apd_pkg.sv @@
// ----------------------------------------------------------------------------
// apd_pkg: shared definitions for the adaptive playout delay estimator
// Default parameter values, configuration register indexes, reset values and port widths.
// ----------------------------------------------------------------------------
`default_nettype none

package apd_pkg;

  // Default build parameters
  localparam int FRAME_SIZE_DEF     = 160;
  localparam int VAR_SHIFT_DEF      = 4;
  localparam int VAR_MULT_SHIFT_DEF = 2;
  localparam int PLAYOUT_SHIFT_DEF  = 3;
  localparam int INITIAL_DELAY_DEF  = 320;

  // Reset value of the max delay register (six times 8000 samples, 48000)
  localparam logic [15:0] MAX_DELAY_RST = 16'(8000 * 6);

  // Configuration port widths
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_MAX_DELAY    = 2'd0,
    CFG_MIN_DELAY    = 2'd1,
    CFG_LECTURE_MODE = 2'd2
  } cfg_idx_t;

  // Stream payload widths
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 72;
  localparam int DELAY_W     = 17;
  localparam int VAR_W       = 16;
  localparam int COUNT_W     = 32;

endpackage

`default_nettype wire

@@ rtl/adaptive_playout_delay.sv @@
// ----------------------------------------------------------------------------
// adaptive_playout_delay: per-packet playout delay estimator
// Pipeline: input register, then result register (loaded when empty or when
//   out_tready is high). Throughput: one packet per cycle when not stalled by
//   out_tready; state updates per packet, so each sees the previous one's state.
// Reset: synchronous active-low rst_n clears both pipeline valids and loads
//   the estimator state and configuration registers with their reset values.
// ----------------------------------------------------------------------------
`default_nettype none

module adaptive_playout_delay #(
  parameter int FRAME_SIZE     = apd_pkg::FRAME_SIZE_DEF,
  parameter int VAR_SHIFT      = apd_pkg::VAR_SHIFT_DEF,
  parameter int VAR_MULT_SHIFT = apd_pkg::VAR_MULT_SHIFT_DEF,
  parameter int PLAYOUT_SHIFT  = apd_pkg::PLAYOUT_SHIFT_DEF,
  parameter int INITIAL_DELAY  = apd_pkg::INITIAL_DELAY_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // configuration write port
  input  wire logic                              cfg_we,
  input  wire logic [apd_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  wire logic [apd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  // packet input stream
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // [31:0] media_timestamp, [63:32] local_time
  input  wire logic [apd_pkg::IN_TDATA_W-1:0]    in_tdata,
  // [0] spurt_start
  input  wire logic                              in_tuser,
  // result stream
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [16:0] playout_delay, [32:17] delay_variance, [64:33] late_total, rest 0
  output logic [apd_pkg::OUT_TDATA_W-1:0]        out_tdata,
  // [0] late
  output logic                                   out_tuser
);

  localparam int VSS = (VAR_SHIFT > VAR_MULT_SHIFT) ? (VAR_SHIFT - VAR_MULT_SHIFT) : 0;
  localparam logic [31:0] VAR_RST     = 32'(INITIAL_DELAY) << VSS;
  localparam logic [31:0] PLAYOUT_RST = 32'(INITIAL_DELAY) << PLAYOUT_SHIFT;
  localparam logic signed [31:0] F1  = 32'(FRAME_SIZE);
  localparam logic signed [31:0] F3  = 32'(3 * FRAME_SIZE);
  localparam logic signed [31:0] F4  = 32'(4 * FRAME_SIZE);
  localparam logic signed [31:0] F5  = 32'(5 * FRAME_SIZE);
  localparam logic signed [31:0] F10 = 32'(10 * FRAME_SIZE);
  localparam int PAD_W = apd_pkg::OUT_TDATA_W - apd_pkg::DELAY_W - apd_pkg::VAR_W
                         - apd_pkg::COUNT_W;

  // configuration registers
  logic [15:0] max_delay_r;
  logic [15:0] min_delay_r;
  logic        lecture_mode_r;

  // estimator state
  logic [31:0] host_offset_r,  host_offset_nxt;
  logic [31:0] variance_acc_r, variance_acc_nxt;
  logic [31:0] playout_acc_r,  playout_acc_nxt;
  logic [31:0] last_transit_r, last_transit_nxt;
  logic [31:0] pred_drop_r,    pred_drop_nxt;
  logic [31:0] late_count_r,   late_count_nxt;

  // input register
  logic        s1_valid_r;
  logic [31:0] s1_ts_r;
  logic [31:0] s1_now_r;
  logic        s1_spurt_r;

  // result register
  logic                            out_valid_r;
  logic                            out_late_r;
  logic [apd_pkg::DELAY_W-1:0]     out_delay_r;
  logic [apd_pkg::VAR_W-1:0]       out_var_r;
  logic [apd_pkg::COUNT_W-1:0]     out_total_r;

  logic advance;
  logic fire;

  // ---------------------------------------------------------------- handshake
  assign advance   = !out_valid_r || out_tready;
  assign fire      = s1_valid_r && advance;
  assign in_tready = !s1_valid_r || advance;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_delay_r    <= apd_pkg::MAX_DELAY_RST;
      min_delay_r    <= 16'(FRAME_SIZE);
      lecture_mode_r <= 1'b0;
    end else if (cfg_we) begin
      case (apd_pkg::cfg_idx_t'(cfg_addr))
        apd_pkg::CFG_MAX_DELAY:    max_delay_r    <= cfg_wdata;
        apd_pkg::CFG_MIN_DELAY:    min_delay_r    <= cfg_wdata;
        apd_pkg::CFG_LECTURE_MODE: lecture_mode_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      s1_valid_r <= 1'b1;
    end else if (fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_ts_r    <= in_tdata[31:0];
      s1_now_r   <= in_tdata[63:32];
      s1_spurt_r <= in_tuser;
    end
  end

  // ---------------------------------------------------------------- shared terms
  logic signed [31:0] maxd, mind, max34, max78;
  logic [17:0]        max_x3;
  logic [18:0]        max_x7;
  logic signed [31:0] nvar, pacc_sh, offset_raw;
  logic [31:0]        transit;

  assign maxd    = {16'b0, max_delay_r};
  assign mind    = {16'b0, min_delay_r};
  assign max_x3  = 18'(max_delay_r) + {1'b0, max_delay_r, 1'b0};
  assign max_x7  = {max_delay_r, 3'b000} - 19'(max_delay_r);
  assign max34   = {16'b0, max_x3[17:2]};
  assign max78   = {16'b0, max_x7[18:3]};
  assign nvar    = $signed(variance_acc_r) >>> VSS;
  assign pacc_sh = $signed(playout_acc_r >> PLAYOUT_SHIFT);
  assign transit = s1_ts_r - s1_now_r;
  assign offset_raw = $signed((s1_ts_r + host_offset_r - s1_now_r) & ~32'd3);

  // ---------------------------------------------------------------- target delay
  logic signed [31:0] pk_off0, pk_diff, pk_neg, pk_step, pk_off1, pick;

  always_comb begin
    pk_off0 = (nvar > maxd) ? maxd : nvar;
    pk_diff = pacc_sh - pk_off0;
    pk_neg  = -pk_diff;
    // lecture mode limits the drop per spurt, conference mode halves it
    if (lecture_mode_r) begin
      if (pk_diff > F1) begin
        pk_step = (pacc_sh > max34 && pk_diff > F10) ? F5 : F1;
      end else begin
        pk_step = pk_diff;
      end
    end else begin
      pk_step = pk_diff >>> 1;
    end
    if (pk_diff > 0) begin
      pk_off1 = pacc_sh - pk_step;
    end else if (pk_neg > maxd) begin
      pk_off1 = max34;
    end else begin
      pk_off1 = pk_off0;
    end
    // clamp to 7/8 of max, then to min
    if (pk_off1 > max78) begin
      pick = max78;
    end else if (pk_off1 < mind) begin
      pick = mind;
    end else begin
      pick = pk_off1;
    end
  end

  // ---------------------------------------------------------------- resync delay
  logic signed [31:0] rs_ad, rs_abs, rs_spurt, rs_spurt_cl, rs_off;
  logic               rs_adj;

  always_comb begin
    rs_ad       = pacc_sh - nvar;
    rs_abs      = (rs_ad < 0) ? -rs_ad : rs_ad;
    rs_adj      = (nvar < F3) || (rs_abs >= F1);
    rs_spurt    = pick - F4;
    rs_spurt_cl = (rs_spurt < mind) ? mind : rs_spurt;
    if (!rs_adj) begin
      rs_off = pacc_sh;
    end else if (s1_spurt_r) begin
      rs_off = rs_spurt_cl;
    end else begin
      rs_off = pick;
    end
  end

  // ---------------------------------------------------------------- state update
  logic               is_resync, is_range, is_late;
  logic signed [31:0] cur_off, var_d;
  logic [31:0]        var_mag;

  always_comb begin
    is_resync = (host_offset_r == 32'd0) || s1_spurt_r;
    is_range  = !is_resync && (offset_raw < 0 || offset_raw > maxd);
    is_late   = is_range && !(offset_raw < 0) && (pred_drop_r != s1_ts_r);
    var_d     = $signed(transit - last_transit_r);
    var_mag   = ((var_d < 0) ? (32'd0 - var_d) : var_d)
                - 32'($signed(variance_acc_r) >>> VAR_SHIFT);

    host_offset_nxt  = host_offset_r;
    variance_acc_nxt = variance_acc_r;
    playout_acc_nxt  = playout_acc_r;
    last_transit_nxt = transit;
    pred_drop_nxt    = pred_drop_r;
    late_count_nxt   = late_count_r;
    cur_off          = offset_raw;

    if (is_resync) begin
      cur_off         = rs_off;
      host_offset_nxt = s1_now_r - s1_ts_r + rs_off;
    end else if (is_range && !is_late) begin
      cur_off         = pick;
      host_offset_nxt = s1_now_r - s1_ts_r + pick;
    end else if (!is_range) begin
      variance_acc_nxt = variance_acc_r + var_mag;
    end

    if (is_late) begin
      pred_drop_nxt  = s1_ts_r + 32'(min_delay_r);
      late_count_nxt = late_count_r + 32'd1;
    end else begin
      playout_acc_nxt = playout_acc_r + (cur_off - (playout_acc_r >> PLAYOUT_SHIFT));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      host_offset_r  <= '0;
      variance_acc_r <= VAR_RST;
      playout_acc_r  <= PLAYOUT_RST;
      last_transit_r <= '0;
      pred_drop_r    <= '1;
      late_count_r   <= '0;
    end else if (fire) begin
      host_offset_r  <= host_offset_nxt;
      variance_acc_r <= variance_acc_nxt;
      playout_acc_r  <= playout_acc_nxt;
      last_transit_r <= last_transit_nxt;
      pred_drop_r    <= pred_drop_nxt;
      late_count_r   <= late_count_nxt;
    end
  end

  // ---------------------------------------------------------------- result fields
  logic signed [31:0]          od, sv;
  logic [apd_pkg::DELAY_W-1:0] delay_nxt;
  logic [apd_pkg::VAR_W-1:0]   var_nxt;

  always_comb begin
    od = cur_off & ~32'sd3;
    // zero delay for a late packet, else clip delay to the 17-bit signed range
    if (is_late) begin
      delay_nxt = '0;
    end else if (od > 32'sd65532) begin
      delay_nxt = 17'h0FFFC;
    end else if (od < -32'sd65536) begin
      delay_nxt = 17'h10000;
    end else begin
      delay_nxt = od[16:0];
    end
    // saturate variance estimate
    sv = $signed(variance_acc_nxt) >>> VAR_SHIFT;
    if (sv < 0) begin
      var_nxt = '0;
    end else if (sv > 32'sd65535) begin
      var_nxt = '1;
    end else begin
      var_nxt = sv[15:0];
    end
  end

  // ---------------------------------------------------------------- result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_late_r  <= is_late;
      out_delay_r <= delay_nxt;
      out_var_r   <= var_nxt;
      out_total_r <= late_count_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_late_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_total_r, out_var_r, out_delay_r};

endmodule

`default_nettype wire

@@ rtl/apd_checker.sv @@
// ----------------------------------------------------------------------------
// apd_checker: port-level checks for the adaptive playout delay estimator
// Watches the result stream for hold under stall, reset and field rules.
// ----------------------------------------------------------------------------
`default_nettype none

module apd_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [apd_pkg::OUT_TDATA_W-1:0] out_tdata,
  input wire logic                           out_tuser
);

  // hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("result changed while stalled");

  // drop result valid after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // late packet carries a zero delay
  a_late_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata[16:0] == 17'd0))
    else $error("late packet with nonzero delay");

  // delay is always a multiple of four, padding is zero
  a_delay_align: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[1:0] == 2'b00 && out_tdata[71:65] == 7'd0))
    else $error("misaligned delay or nonzero padding");

endmodule

bind adaptive_playout_delay apd_checker u_apd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
